// File: hw/rtl/wrgd_pkg.sv
// Shared constants and types for the wrist raise gesture detector.
// No dependencies; used by the channel interfaces and the core.
package wrgd_pkg;

	localparam int HISTORY_DEPTH_DEF = 15;
	localparam int SAMPLE_WIDTH_DEF  = 16;

	localparam int UNIT_FRAC   = 12;   // Q1.12 unit vector
	localparam int UNIT_W      = 14;   // signed unit component width
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int CONFIRM_W   = 4;
	localparam logic [CONFIRM_W-1:0] CONFIRM_MAX = 4'd15;

	// 0.5 g in Q3.14, squared
	localparam longint HALF_G_GRAV    = 8192;
	localparam longint HALF_G_GRAV_SQ = HALF_G_GRAV * HALF_G_GRAV;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISPLAY_ROTATION  = 3'd0,
		REG_FACE_UP_THRESHOLD = 3'd1,
		REG_RAISE_DELTA       = 3'd2,
		REG_RAISE_ANGLE_COS   = 3'd3,
		REG_LEAN_MINIMUM      = 3'd4,
		REG_STATIC_LOW        = 3'd5,
		REG_STATIC_HIGH       = 3'd6,
		REG_CONFIRM_SAMPLES   = 3'd7
	} cfg_idx_t;

	// Display rotation codes
	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	// Sample op codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_RESET  = 1'b1;

	// Register reset values
	localparam logic [12:0]        FACE_UP_RST   = 13'd2540;
	localparam logic [13:0]        RAISE_DLT_RST = 14'd614;
	localparam logic signed [13:0] RAISE_COS_RST = 14'sd3547;
	localparam logic signed [13:0] LEAN_MIN_RST  = -14'sd696;
	localparam logic [14:0]        STATIC_LO_RST = 15'd3072;
	localparam logic [14:0]        STATIC_HI_RST = 15'd5120;
	localparam logic [3:0]         CONFIRM_RST   = 4'd2;

endpackage

// File: hw/rtl/wrgd_if.sv
// Valid/ready channel interfaces: samples in, wake results out, register writes.
// Depends on wrgd_pkg.
interface wrgd_in_if import wrgd_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic signed [SAMPLE_WIDTH-1:0] accel_x;
	logic signed [SAMPLE_WIDTH-1:0] accel_y;
	logic signed [SAMPLE_WIDTH-1:0] accel_z;

	modport source (output valid, op, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, op, accel_x, accel_y, accel_z, output ready);
endinterface

interface wrgd_out_if;
	logic valid;
	logic ready;
	logic wake;

	modport source (output valid, wake, input ready);
	modport sink   (input valid, wake, output ready);
endinterface

interface wrgd_cfg_if import wrgd_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/wrist_raise_gesture_detector_core.sv
// Wrist raise gesture detector core: sequencer around one shared multiplier,
// an iterative square root / divider and a history memory.
// Depends on wrgd_pkg and the channel interfaces in wrgd_if.sv.
//
// A reset op goes straight to the result state; the time a sample takes is
// set by the bit-serial root, the per-bit divider and the entry-by-entry
// history scan. One item at a time.
// Reset: arst_n clears control state and loads register defaults; history
// entries are only read below the fill count, so the memory is not cleared.
module wrist_raise_gesture_detector_core import wrgd_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	wrgd_in_if.sink    samples,
	wrgd_out_if.source result,
	wrgd_cfg_if.sink   cfg
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int GW   = SW + 2;                 // gravity Q3.14
	localparam int MW   = (GW > 16) ? GW : 16;    // multiplier operand
	localparam int PW   = 2 * MW;
	localparam int ACW  = PW + 2;
	localparam int XW   = 2 * GW + 2;             // root radicand
	localparam int NRT  = XW / 2;                 // root iterations
	localparam int RW   = GW + 1;                 // root width
	localparam int NW   = GW + 15;                // divider width
	localparam int QW   = UNIT_FRAC + 1;
	localparam int HA   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW   = $clog2(HISTORY_DEPTH + 1);
	localparam int HWD  = 3 * UNIT_W;
	localparam int STW  = $clog2(NRT + 1);
	localparam int DW   = 2 * UNIT_W + 2;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_MAG   = 14'b00000000000010,
		ST_EMA   = 14'b00000000000100,
		ST_GSQ   = 14'b00000000001000,
		ST_GCHK  = 14'b00000000010000,
		ST_SQRT  = 14'b00000000100000,
		ST_DSET  = 14'b00000001000000,
		ST_DIV   = 14'b00000010000000,
		ST_SLD   = 14'b00000100000000,
		ST_SDOT  = 14'b00001000000000,
		ST_SCMP  = 14'b00010000000000,
		ST_PUSH  = 14'b00100000000000,
		ST_DEC   = 14'b01000000000000,
		ST_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [1:0]         rot_q;
	logic [12:0]        face_up_q;
	logic [13:0]        raise_dlt_q;
	logic signed [13:0] raise_cos_q;
	logic signed [13:0] lean_min_q;
	logic [14:0]        static_lo_q;
	logic [14:0]        static_hi_q;
	logic [3:0]         confirm_smp_q;

	// Detector state
	logic signed [GW-1:0]     grav_q [3];
	logic                     grav_valid_q;
	logic [HA-1:0]            head_q;
	logic [FW-1:0]            fill_q;
	logic [CONFIRM_W-1:0]     confirm_cnt_q;
	logic [HWD-1:0]           hist_mem [HISTORY_DEPTH];
	logic [HWD-1:0]           hist_rd_q;

	// Working registers
	logic signed [SW-1:0]     accel_q [3];
	logic [2:0]               k_q;
	logic signed [ACW-1:0]    acc_q;
	logic [29:0]              sq_lo_q;
	logic [29:0]              sq_hi_q;
	logic                     mag_ok_q;
	logic [XW-1:0]            x_q;
	logic [RW+1:0]            rem_q;
	logic [RW-1:0]            root_q;
	logic [STW-1:0]           step_q;
	logic [NW-1:0]            drem_q;
	logic [NW-1:0]            dsh_q;
	logic [QW-1:0]            quo_q;
	logic signed [UNIT_W-1:0] gu_q [3];
	logic [FW-1:0]            idx_q;
	logic                     found_q;
	logic signed [UNIT_W:0]   up_min_q;
	logic signed [DW-1:0]     dot_min_q;
	logic                     full_q;
	logic                     wake_q;
	logic                     res_valid_q;
	logic                     res_wake_q;

	// Shared multiplier operand select
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MAG: begin
				if (k_q == 3'd3) begin
					mul_a = MW'(signed'({1'b0, static_lo_q}));
				end else if (k_q == 3'd4) begin
					mul_a = MW'(signed'({1'b0, static_hi_q}));
				end else begin
					mul_a = MW'(accel_q[k_q[1:0]]);
				end
				mul_b = mul_a;
			end
			ST_GSQ: begin
				mul_a = MW'(grav_q[k_q[1:0]]);
				mul_b = mul_a;
			end
			ST_SDOT: begin
				mul_a = MW'(gu_q[k_q[1:0]]);
				unique case (k_q[1:0])
					2'd0:    mul_b = MW'(signed'(hist_rd_q[HWD-1 -: UNIT_W]));
					2'd1:    mul_b = MW'(signed'(hist_rd_q[2*UNIT_W-1 -: UNIT_W]));
					default: mul_b = MW'(signed'(hist_rd_q[UNIT_W-1:0]));
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Magnitude window test on the summed squares
	logic mag_ok;
	assign mag_ok = ($unsigned(acc_q) > ACW'(sq_lo_q)) && ($unsigned(acc_q) < ACW'(sq_hi_q));

	// EMA of gravity, alpha one half (arithmetic shift is floor)
	logic signed [GW-1:0] grav_n [3];
	always_comb begin
		logic signed [GW:0] s;
		for (int i = 0; i < 3; i++) begin
			s = (GW+1)'(accel_q[i]) <<< 2;
			if (grav_valid_q) begin
				s = ((GW+1)'(grav_q[i]) + s) >>> 1;
			end
			grav_n[i] = GW'(s);
		end
	end

	// Root step: bring down two radicand bits, try subtract
	logic [RW+1:0] rem_sh, trial;
	logic          root_hit;
	assign rem_sh   = {rem_q[RW-1:0], x_q[XW-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign root_hit = rem_sh >= trial;

	// Divider step and operand for the current component
	logic          div_hit;
	logic [QW-1:0] quo_n;
	logic [GW:0]   gabs;
	assign div_hit = drem_q >= dsh_q;
	assign quo_n   = quo_q | (QW'(div_hit) << step_q);
	always_comb begin
		logic signed [GW:0] gx;
		gx   = (GW+1)'(grav_q[k_q[1:0]]);
		gabs = (gx < 0) ? $unsigned(-gx) : $unsigned(gx);
	end

	// History entry under scan
	logic signed [UNIT_W:0] up_h;
	logic                   off_face;
	assign up_h     = -(UNIT_W+1)'(signed'(hist_rd_q[UNIT_W-1:0]));
	assign off_face = up_h < (UNIT_W+1)'(signed'({2'b00, face_up_q}));

	// Final decision terms
	logic signed [UNIT_W:0] up, lean;
	logic                   settled;
	logic [CONFIRM_W-1:0]   cnt_n;
	logic signed [UNIT_W+1:0] rise;
	logic                   raise_ok;
	assign up = -(UNIT_W+1)'(gu_q[2]);
	always_comb begin
		unique case (rot_t'(rot_q))
			ROT_0:   lean = -(UNIT_W+1)'(gu_q[0]);
			ROT_90:  lean = (UNIT_W+1)'(gu_q[1]);
			ROT_180: lean = (UNIT_W+1)'(gu_q[0]);
			ROT_270: lean = -(UNIT_W+1)'(gu_q[1]);
			default: lean = '0;
		endcase
	end
	assign settled  = (up > (UNIT_W+1)'(signed'({2'b00, face_up_q})))
		&& (lean >= (UNIT_W+1)'(lean_min_q)) && mag_ok_q;
	assign cnt_n    = (confirm_cnt_q < CONFIRM_MAX) ? confirm_cnt_q + 1'b1 : confirm_cnt_q;
	assign rise     = (UNIT_W+2)'(up) - (UNIT_W+2)'(up_min_q);
	assign raise_ok = (rise >= (UNIT_W+2)'(signed'({1'b0, raise_dlt_q})))
		|| (dot_min_q <= (DW'(raise_cos_q) <<< UNIT_FRAC));

	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign result.valid  = res_valid_q;
	assign result.wake   = res_wake_q;

	// History memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH) begin
			hist_mem[head_q] <= {gu_q[0], gu_q[1], gu_q[2]};
		end
		hist_rd_q <= hist_mem[idx_q[HA-1:0]];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q         <= '0;
			face_up_q     <= FACE_UP_RST;
			raise_dlt_q   <= RAISE_DLT_RST;
			raise_cos_q   <= RAISE_COS_RST;
			lean_min_q    <= LEAN_MIN_RST;
			static_lo_q   <= STATIC_LO_RST;
			static_hi_q   <= STATIC_HI_RST;
			confirm_smp_q <= CONFIRM_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_DISPLAY_ROTATION:  rot_q         <= cfg.data[1:0];
				REG_FACE_UP_THRESHOLD: face_up_q     <= cfg.data[12:0];
				REG_RAISE_DELTA:       raise_dlt_q   <= cfg.data[13:0];
				REG_RAISE_ANGLE_COS:   raise_cos_q   <= signed'(cfg.data[13:0]);
				REG_LEAN_MINIMUM:      lean_min_q    <= signed'(cfg.data[13:0]);
				REG_STATIC_LOW:        static_lo_q   <= cfg.data[14:0];
				REG_STATIC_HIGH:       static_hi_q   <= cfg.data[14:0];
				REG_CONFIRM_SAMPLES:   confirm_smp_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				accel_q[0] <= samples.accel_x;
				accel_q[1] <= samples.accel_y;
				accel_q[2] <= samples.accel_z;
				acc_q      <= '0;
				k_q        <= '0;
			end
			ST_MAG: begin
				if (k_q == 3'd3) begin
					sq_lo_q <= prod[29:0];
				end else if (k_q == 3'd4) begin
					sq_hi_q <= prod[29:0];
				end else begin
					acc_q <= acc_q + ACW'(prod);
				end
				k_q <= k_q + 1'b1;
			end
			ST_EMA: begin
				mag_ok_q <= mag_ok;
				if (mag_ok) begin
					for (int i = 0; i < 3; i++) grav_q[i] <= grav_n[i];
				end
				acc_q <= '0;
				k_q   <= '0;
			end
			ST_GSQ: begin
				acc_q <= acc_q + ACW'(prod);
				k_q   <= k_q + 1'b1;
			end
			ST_GCHK: begin
				x_q    <= XW'($unsigned(acc_q));
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
				k_q    <= '0;
			end
			ST_SQRT: begin
				x_q    <= x_q << 2;
				rem_q  <= root_hit ? rem_sh - trial : rem_sh;
				root_q <= {root_q[RW-2:0], root_hit};
				step_q <= step_q + 1'b1;
			end
			ST_DSET: begin
				drem_q <= (NW'(gabs) << (UNIT_FRAC + 1)) + NW'(root_q);
				dsh_q  <= NW'(root_q) << (UNIT_FRAC + 1);
				quo_q  <= '0;
				step_q <= STW'(UNIT_FRAC);
			end
			ST_DIV: begin
				if (div_hit) drem_q <= drem_q - dsh_q;
				dsh_q  <= dsh_q >> 1;
				quo_q  <= quo_n;
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					gu_q[k_q[1:0]] <= grav_q[k_q[1:0]] < 0
						? -UNIT_W'(signed'({1'b0, quo_n}))
						: UNIT_W'(signed'({1'b0, quo_n}));
					k_q <= k_q + 1'b1;
				end
			end
			ST_SLD: begin
				acc_q <= '0;
				k_q   <= '0;
			end
			ST_SDOT: begin
				acc_q <= acc_q + ACW'(prod);
				k_q   <= k_q + 1'b1;
			end
			ST_SCMP: begin
				if (off_face) begin
					if (!found_q || up_h < up_min_q) up_min_q <= up_h;
					if (!found_q || DW'(acc_q) < dot_min_q) dot_min_q <= DW'(acc_q);
				end
			end
			default: ;
		endcase
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			grav_valid_q  <= 1'b0;
			head_q        <= '0;
			fill_q        <= '0;
			confirm_cnt_q <= '0;
			idx_q         <= '0;
			found_q       <= 1'b0;
			full_q        <= 1'b0;
			wake_q        <= 1'b0;
			res_valid_q   <= 1'b0;
			res_wake_q    <= 1'b0;
		end else begin
			// result taken; the finishing state loads the register itself
			if (res_valid_q && result.ready && (state_q != ST_DONE)) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					wake_q <= 1'b0;
					if (samples.valid) begin
						if (samples.op == OP_RESET) begin
							grav_valid_q  <= 1'b0;
							head_q        <= '0;
							fill_q        <= '0;
							confirm_cnt_q <= '0;
							state_q       <= ST_DONE;
						end else begin
							state_q <= ST_MAG;
						end
					end
				end
				ST_MAG: if (k_q == 3'd4) state_q <= ST_EMA;
				ST_EMA: begin
					if (mag_ok) grav_valid_q <= 1'b1;
					state_q <= (mag_ok || grav_valid_q) ? ST_GSQ : ST_DONE;
				end
				ST_GSQ: if (k_q == 3'd2) state_q <= ST_GCHK;
				ST_GCHK: begin
					state_q <= ($unsigned(acc_q) < ACW'(HALF_G_GRAV_SQ)) ? ST_DONE : ST_SQRT;
				end
				ST_SQRT: if (step_q == STW'(NRT - 1)) state_q <= ST_DSET;
				ST_DSET: state_q <= ST_DIV;
				ST_DIV: begin
					if (step_q == '0) begin
						if (k_q == 3'd2) begin
							idx_q   <= '0;
							found_q <= 1'b0;
							state_q <= (fill_q == '0) ? ST_PUSH : ST_SLD;
						end else begin
							state_q <= ST_DSET;
						end
					end
				end
				ST_SLD:  state_q <= ST_SDOT;
				ST_SDOT: if (k_q == 3'd2) state_q <= ST_SCMP;
				ST_SCMP: begin
					if (off_face) found_q <= 1'b1;
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 < fill_q) ? ST_SLD : ST_PUSH;
				end
				ST_PUSH: begin
					full_q  <= fill_q >= FW'(HISTORY_DEPTH);
					head_q  <= (head_q == HA'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
					if (fill_q < FW'(HISTORY_DEPTH)) fill_q <= fill_q + 1'b1;
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (!settled) begin
						confirm_cnt_q <= '0;
					end else begin
						confirm_cnt_q <= cnt_n;
						if (cnt_n >= confirm_smp_q && full_q && found_q && raise_ok) begin
							wake_q        <= 1'b1;
							grav_valid_q  <= 1'b0;
							head_q        <= '0;
							fill_q        <= '0;
							confirm_cnt_q <= '0;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						res_wake_q  <= wake_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: test/wrgd_wake_checker.sv
// Scoreboard for the wrist raise gesture detector: tracks register writes,
// predicts the wake bit per accepted item and compares results in order.
// Depends on wrgd_pkg.
module wrgd_wake_checker import wrgd_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              in_op,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] ax,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] ay,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] az,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              out_wake,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [CFG_IDX_W-1:0]              cfg_index,
	input  logic [CFG_DATA_W-1:0]             cfg_data,
	output int                                errors,
	output int                                pending,
	output int                                wakes_seen
);

	localparam int DEPTH = HISTORY_DEPTH_DEF;
	localparam longint ONE = 4096;

	// register copies
	logic [1:0] rot;
	longint face_up, rise_min, cos_min, lean_min, conf_req;
	longint unsigned mag_lo, mag_hi;

	// detector state copy
	longint grav [3];
	bit     grav_ok;
	longint dir_hist [DEPTH][3];
	int     head, fill;
	longint conf_cnt;

	bit wake_q [$];

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// g * 4096 / |g|, nearest, ties away from zero
	function automatic longint unit_of(input longint g, input longint unsigned mag);
		longint unsigned a, q;
		a = (g < 0) ? -g : g;
		q = (2 * a * ONE + mag) / (2 * mag);
		return (g < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic void clear_detector();
		grav_ok  = 0;
		head     = 0;
		fill     = 0;
		conf_cnt = 0;
	endfunction

	function automatic bit predict_wake(input logic op, input longint x, input longint y,
			input longint z);
		longint a [3];
		longint gu [3];
		longint up, lean, up_lo, dot_lo, uph, d, s;
		longint unsigned msq, gsq, gmag;
		bit mag_ok, found, full, settled;
		up_lo = 0;
		dot_lo = 0;
		found = 0;
		if (op == OP_RESET) begin
			clear_detector();
			return 0;
		end
		a[0] = x; a[1] = y; a[2] = z;
		msq = x * x + y * y + z * z;
		mag_ok = msq > mag_lo * mag_lo && msq < mag_hi * mag_hi;
		// EMA, alpha one half, floor division
		if (mag_ok) begin
			for (int k = 0; k < 3; k++) begin
				s = a[k] * 4;
				grav[k] = grav_ok ? ((grav[k] + s) >>> 1) : s;
			end
			grav_ok = 1;
		end
		if (!grav_ok) return 0;
		gsq = grav[0] * grav[0] + grav[1] * grav[1] + grav[2] * grav[2];
		if (gsq < HALF_G_GRAV_SQ) return 0;
		gmag = root_floor(gsq);
		for (int k = 0; k < 3; k++) gu[k] = unit_of(grav[k], gmag);
		up = -gu[2];
		// scan off-face history entries
		for (int i = 0; i < fill && i < DEPTH; i++) begin
			uph = -dir_hist[i][2];
			if (uph < face_up) begin
				d = gu[0] * dir_hist[i][0] + gu[1] * dir_hist[i][1] + gu[2] * dir_hist[i][2];
				if (!found || uph < up_lo) up_lo = uph;
				if (!found || d < dot_lo) dot_lo = d;
				found = 1;
			end
		end
		full = fill >= DEPTH;
		if (head >= DEPTH) head = 0;
		for (int k = 0; k < 3; k++) dir_hist[head][k] = gu[k];
		head = (head + 1) % DEPTH;
		if (fill < DEPTH) fill++;
		case (rot_t'(rot))
			ROT_0:   lean = -gu[0];
			ROT_90:  lean = gu[1];
			ROT_180: lean = gu[0];
			default: lean = -gu[1];
		endcase
		settled = up > face_up && lean >= lean_min && mag_ok;
		if (!settled) begin
			conf_cnt = 0;
			return 0;
		end
		if (conf_cnt < CONFIRM_MAX) conf_cnt++;
		if (conf_cnt < conf_req) return 0;
		if (full && found && ((up - up_lo) >= rise_min || dot_lo <= cos_min * ONE)) begin
			clear_detector();
			return 1;
		end
		return 0;
	endfunction

	assign pending = wake_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot      <= ROT_0;
			face_up  <= FACE_UP_RST;
			rise_min <= RAISE_DLT_RST;
			cos_min  <= RAISE_COS_RST;
			lean_min <= LEAN_MIN_RST;
			mag_lo   <= STATIC_LO_RST;
			mag_hi   <= STATIC_HI_RST;
			conf_req <= CONFIRM_RST;
			clear_detector();
			wake_q.delete();
			errors     <= 0;
			wakes_seen <= 0;
		end else begin
			// result side first: an item accepted now cannot answer this edge
			if (out_valid && out_ready) begin
				if (wake_q.size() == 0) begin
					report_mismatch($sformatf("wake=%0b with no item outstanding", out_wake));
				end else begin
					if (out_wake !== wake_q[0])
						report_mismatch($sformatf("wake got %0b, want %0b", out_wake, wake_q[0]));
					void'(wake_q.pop_front());
				end
				if (out_wake === 1'b1) wakes_seen <= wakes_seen + 1;
			end
			if (in_valid && in_ready)
				wake_q.push_back(predict_wake(in_op, ax, ay, az));
			// register writes, masked to width
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					REG_DISPLAY_ROTATION:  rot      <= cfg_data[1:0];
					REG_FACE_UP_THRESHOLD: face_up  <= cfg_data[12:0];
					REG_RAISE_DELTA:       rise_min <= cfg_data[13:0];
					REG_RAISE_ANGLE_COS:   cos_min  <= $signed(cfg_data[13:0]);
					REG_LEAN_MINIMUM:      lean_min <= $signed(cfg_data[13:0]);
					REG_STATIC_LOW:        mag_lo   <= cfg_data[14:0];
					REG_STATIC_HIGH:       mag_hi   <= cfg_data[14:0];
					REG_CONFIRM_SAMPLES:   conf_req <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// File: test/wrist_raise_gesture_detector_core_tb.sv
// Top of the wrist raise detector testbench: clock, reset, stimulus, idling
// and verdict. Depends on wrgd_pkg, wrgd_if.sv, the core and wrgd_wake_checker.
module wrist_raise_gesture_detector_core_tb;
	import wrgd_pkg::*;

	localparam int PHASE_ITEMS = 150;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int   errors, pending, wakes_seen;
	int   items_sent, resets_sent, results_taken, cycles;

	wrgd_in_if  samples_if ();
	wrgd_out_if result_if ();
	wrgd_cfg_if cfg_if ();

	wrist_raise_gesture_detector_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.result  (result_if),
		.cfg     (cfg_if)
	);

	wrgd_wake_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (samples_if.valid),
		.in_ready   (samples_if.ready),
		.in_op      (samples_if.op),
		.ax         (samples_if.accel_x),
		.ay         (samples_if.accel_y),
		.az         (samples_if.accel_z),
		.out_valid  (result_if.valid),
		.out_ready  (result_if.ready),
		.out_wake   (result_if.wake),
		.cfg_valid  (cfg_if.valid),
		.cfg_ready  (cfg_if.ready),
		.cfg_index  (cfg_if.index),
		.cfg_data   (cfg_if.data),
		.errors     (errors),
		.pending    (pending),
		.wakes_seen (wakes_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
				$display("wrist_raise_gesture_detector_core_tb failed");
				$finish;
			end
		end
	end

	// result receiver: random stalls, bursts without stalls, one long hold-off
	initial begin
		int  wait_n;
		bit  burst;
		bit  held;
		burst = 0;
		held = 0;
		results_taken = 0;
		result_if.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 49) == 0) burst = !burst;
			wait_n = burst ? 0 : $urandom_range(0, 14);
			if (!held && results_taken == 200) begin
				held = 1;
				wait_n = 600;
			end
			if (wait_n > 0) begin
				result_if.ready <= 0;
				repeat (wait_n) @(negedge clk);
			end
			result_if.ready <= 1;
			do @(posedge clk); while (!result_if.valid);
			results_taken++;
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input int val);
		@(negedge clk);
		cfg_if.valid <= 1;
		cfg_if.index <= idx;
		cfg_if.data  <= 16'(val);
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 0;
	endtask

	// one item; valid stays high across back-to-back items
	task automatic send_item(input logic op, input int x, input int y, input int z);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			samples_if.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid   <= 1;
		samples_if.op      <= op;
		samples_if.accel_x <= 16'(x);
		samples_if.accel_y <= 16'(y);
		samples_if.accel_z <= 16'(z);
		do @(posedge clk); while (!samples_if.ready);
		@(negedge clk);
		items_sent++;
		if (op == OP_RESET) resets_sent++;
	endtask

	function automatic int jitter(input int v, input int amp);
		return v + $urandom_range(0, 2 * amp) - amp;
	endfunction

	// arm hanging, then turned face up; some with shakes or a reset mixed in
	task automatic raise_gesture();
		int n_down, n_up, amp, ax_sel, sgn;
		n_down = $urandom_range(3, 20);
		n_up = $urandom_range(1, 6);
		amp = $urandom_range(0, 1) ? 150 : 900;
		for (int i = 0; i < n_down; i++) begin
			ax_sel = $urandom_range(0, 2);
			sgn = $urandom_range(0, 1) ? 4096 : -4096;
			if ($urandom_range(0, 19) == 0)
				send_item(OP_SAMPLE, $urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			else if (ax_sel == 0)
				send_item(OP_SAMPLE, jitter(sgn, amp), jitter(0, amp), jitter(0, amp));
			else if (ax_sel == 1)
				send_item(OP_SAMPLE, jitter(0, amp), jitter(sgn, amp), jitter(0, amp));
			else
				send_item(OP_SAMPLE, jitter(0, amp), jitter(0, amp), jitter(4096, amp));
		end
		for (int i = 0; i < n_up; i++)
			send_item(OP_SAMPLE, jitter(0, 400), jitter(0, 400), jitter(-4096, 300));
		if ($urandom_range(0, 9) == 0) send_item(OP_RESET, $urandom, $urandom, $urandom);
	endtask

	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	initial begin
		int vals [8];
		int start;
		arst_n = 0;
		items_sent = 0;
		resets_sent = 0;
		samples_if.valid = 0;
		samples_if.op = OP_SAMPLE;
		samples_if.accel_x = 0;
		samples_if.accel_y = 0;
		samples_if.accel_z = 0;
		cfg_if.valid = 0;
		cfg_if.index = REG_DISPLAY_ROTATION;
		cfg_if.data = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: field extremes, static bounds, gravity cancelling, resets
		send_item(OP_SAMPLE, 0, 0, 0);
		send_item(OP_SAMPLE, -32768, -32768, -32768);
		send_item(OP_SAMPLE, 32767, 32767, 32767);
		send_item(OP_SAMPLE, 3072, 0, 0);
		send_item(OP_SAMPLE, 5120, 0, 0);
		send_item(OP_SAMPLE, 4096, 0, 0);
		send_item(OP_SAMPLE, -4096, 0, 0);
		send_item(OP_SAMPLE, 0, 0, -3073);
		send_item(OP_SAMPLE, 0, 0, 5119);
		send_item(OP_RESET, -1, -1, -1);
		send_item(OP_SAMPLE, 0, -4096, 0);
		send_item(OP_RESET, 0, 0, 0);
		for (int i = 0; i < 9; i++)
			send_item(OP_SAMPLE, (i % 2) ? 4096 : 0, (i % 2) ? 0 : -4096, 0);
		for (int i = 0; i < 4; i++) send_item(OP_SAMPLE, 0, 0, -4096);
		samples_if.valid <= 0;
		wait_idle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: vals = '{0, 2540, 614, 3547, -696, 3072, 5120, 2};
				1: vals = '{1, 0, 0, -4096, -4096, 0, 32767, 1};
				2: vals = '{2, 4096, 8192, 4096, 4096, 32767, 0, 15};
				3: vals = '{3, 2540, 614, 3547, -696, 3072, 5120, 0};
				4: vals = '{0, 65535, 65535, 65535, 65535, 65535, 65535, 65535};
				5: vals = '{1, 2000, 300, 3900, -2000, 3500, 4700, 3};
				default: vals = '{$urandom_range(0, 3), $urandom_range(0, 4096),
					$urandom_range(0, 8192), $urandom_range(0, 8192) - 4096,
					$urandom_range(0, 8192) - 4096, $urandom_range(1000, 3800),
					$urandom_range(4400, 9000), $urandom_range(1, 15)};
			endcase
			for (int r = 0; r < 8; r++) write_reg(cfg_idx_t'(r), vals[r]);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					send_item($urandom_range(0, 1), $urandom, $urandom, $urandom);
				else
					raise_gesture();
			end
			samples_if.valid <= 0;
			wait_idle();
		end

		$display("%0d items (%0d detector resets) over 8 register settings, %0d wakes",
			items_sent, resets_sent, wakes_seen);
		if (errors == 0 && pending == 0)
			$display("wrist_raise_gesture_detector_core_tb passed");
		else
			$display("wrist_raise_gesture_detector_core_tb failed");
		$finish;
	end

endmodule
